// ----- hdl/msdc_pkg.sv -----
`timescale 1ns / 1ps

package msdc_pkg;

    // Defaults for the top level parameters
    localparam int MAX_INTERIOR_DEF = 1024;
    localparam int MAX_BOUNDARY_DEF = 1024;
    localparam int COORD_BITS_DEF   = 12;

    // Fixed payload widths
    localparam int ACTION_W = 2;
    localparam int PIX_W    = 12;
    localparam int IDX_W    = 10;
    localparam int SUM_W    = 31;

    // Squared distance is scaled by 2^16 before the root: 8 fraction bits out
    localparam int FRAC_SHIFT = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_INT = 2'd0,
        ACT_LOAD_BND = 2'd1,
        ACT_COMPUTE  = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INT_CAP,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_ACC,
        S_CMP,
        S_FINISH
    } t_state;

endpackage

// ----- hdl/msdc_if.sv -----
`timescale 1ns / 1ps

interface msdc_in_if import msdc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_action              action;
    logic [PIX_W-1:0]     point_x;
    logic [PIX_W-1:0]     point_y;

    modport source (output valid, output action, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input action, input point_x, input point_y,
                    output ready);
endinterface

interface msdc_out_if import msdc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     center_x;
    logic [PIX_W-1:0]     center_y;
    logic [IDX_W-1:0]     center_index;
    logic [SUM_W-1:0]     total_distance;
    logic                 empty_res;

    modport source (output valid, output center_x, output center_y,
                    output center_index, output total_distance, output empty_res,
                    input ready);
    modport sink   (input valid, input center_x, input center_y,
                    input center_index, input total_distance, input empty_res,
                    output ready);
endinterface

// ----- hdl/msdc_ram.sv -----
`timescale 1ns / 1ps

module msdc_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/min_sum_distance_center.sv -----
`timescale 1ns / 1ps
// Minimum-sum-distance centre of a set of interior points against a boundary.
// Input channel i_in (valid/ready): each transaction carries an action and a
// point. Load-interior and load-boundary append the point to their store,
// so loads stream at one per cycle while i_in is ready; a load into a full
// store is dropped. Clear empties both stores.
// Compute runs the whole search and yields one transaction on o_out: the
// interior point with the smallest sum of Euclidean distances (8 fraction
// bits) to all boundary points, the earliest on a tie, or empty_res = 1.
// Compute handles one pair at a time through the bit-serial square root, one
// root bit per cycle, shared by every pair; with no interior point it goes
// straight to the final step. i_in is not ready while a compute is under way.
// Reset (synchronous, active low) empties both stores and drops any pending
// result. The result sits in an output register: further loads are accepted
// while o_out is stalled, and a later compute holds in its final step until
// the previous result has been taken.

module min_sum_distance_center
    import msdc_pkg::*;
#(
    parameter int MAX_INTERIOR = MAX_INTERIOR_DEF,
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    msdc_in_if.sink         i_in,
    msdc_out_if.source      o_out
);

    // Store geometry
    localparam int CW_I = $clog2(MAX_INTERIOR + 1);
    localparam int CW_B = $clog2(MAX_BOUNDARY + 1);
    localparam int AW_I = (MAX_INTERIOR > 1) ? $clog2(MAX_INTERIOR) : 1;
    localparam int AW_B = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
    localparam int PW   = 2 * COORD_BITS;

    // Root datapath: radicand is (dx^2 + dy^2) << 16, below 2^(2*COORD_BITS+17)
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int D2_W  = SQ_W + 1;
    localparam int ITER  = COORD_BITS + 9;
    localparam int RAD_W = 2 * ITER;
    localparam int KW    = $clog2(ITER);

    t_state                r_state,    n_state;
    logic [CW_I-1:0]       r_int_cnt,  n_int_cnt;
    logic [CW_B-1:0]       r_bnd_cnt,  n_bnd_cnt;
    logic [CW_I-1:0]       r_i,        n_i;
    logic [CW_B-1:0]       r_j,        n_j;
    logic                  r_empty,    n_empty;
    logic [PW-1:0]         r_pt,       n_pt;
    logic [COORD_BITS-1:0] r_dx,       n_dx;
    logic [COORD_BITS-1:0] r_dy,       n_dy;
    logic [SQ_W-1:0]       r_sqx,      n_sqx;
    logic [RAD_W-1:0]      r_rad,      n_rad;
    logic [ITER-1:0]       r_root,     n_root;
    logic [ITER+1:0]       r_rem,      n_rem;
    logic [KW-1:0]         r_k,        n_k;
    logic [SUM_W-1:0]      r_sum,      n_sum;
    logic [SUM_W-1:0]      r_best,     n_best;
    logic [CW_I-1:0]       r_best_i,   n_best_i;
    logic [PW-1:0]         r_best_pt,  n_best_pt;
    logic                  r_out_valid, n_out_valid;
    logic [PIX_W-1:0]      r_out_x,    n_out_x;
    logic [PIX_W-1:0]      r_out_y,    n_out_y;
    logic [IDX_W-1:0]      r_out_idx,  n_out_idx;
    logic [SUM_W-1:0]      r_out_sum,  n_out_sum;
    logic                  r_out_empty, n_out_empty;

    logic                  w_accept;
    logic [PW-1:0]         w_load_pt;
    logic                  w_int_we;
    logic                  w_bnd_we;
    logic [PW-1:0]         w_int_rd;
    logic [PW-1:0]         w_bnd_rd;
    logic [COORD_BITS-1:0] w_ax, w_ay, w_bx, w_by;
    logic [COORD_BITS-1:0] w_mul_in;
    logic [SQ_W-1:0]       w_prod;
    logic [D2_W-1:0]       w_d2;
    logic [ITER+1:0]       w_rem_sh;
    logic [ITER+1:0]       w_trial;
    logic                  w_ge;
    logic [SUM_W:0]        w_acc;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load_pt  = {COORD_BITS'(i_in.point_x), COORD_BITS'(i_in.point_y)};

    // Point stores: the read address follows the next index, so the registered
    // read data always shows the entry at the current index
    msdc_ram #(.WIDTH(PW), .DEPTH(MAX_INTERIOR)) u_int_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_int_we),
        .i_wr_addr (r_int_cnt[AW_I-1:0]),
        .i_wr_data (w_load_pt),
        .i_rd_addr (n_i[AW_I-1:0]),
        .o_rd_data (w_int_rd)
    );

    msdc_ram #(.WIDTH(PW), .DEPTH(MAX_BOUNDARY)) u_bnd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_bnd_we),
        .i_wr_addr (r_bnd_cnt[AW_B-1:0]),
        .i_wr_data (w_load_pt),
        .i_rd_addr (n_j[AW_B-1:0]),
        .o_rd_data (w_bnd_rd)
    );

    // Pair datapath
    assign w_ax = r_pt[PW-1 -: COORD_BITS];
    assign w_ay = r_pt[COORD_BITS-1:0];
    assign w_bx = w_bnd_rd[PW-1 -: COORD_BITS];
    assign w_by = w_bnd_rd[COORD_BITS-1:0];

    // One squarer, used for dx then dy
    assign w_mul_in = (r_state == S_SQY) ? r_dy : r_dx;
    assign w_prod   = SQ_W'(w_mul_in) * SQ_W'(w_mul_in);
    assign w_d2     = D2_W'(r_sqx) + D2_W'(w_prod);

    // Restoring square root, one result bit per cycle
    assign w_rem_sh = {r_rem[ITER-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    // Saturating accumulation of the distance sum
    assign w_acc = {1'b0, r_sum} + (SUM_W + 1)'(r_root);

    always_comb begin
        n_state     = r_state;
        n_int_cnt   = r_int_cnt;
        n_bnd_cnt   = r_bnd_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_empty     = r_empty;
        n_pt        = r_pt;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sqx       = r_sqx;
        n_rad       = r_rad;
        n_root      = r_root;
        n_rem       = r_rem;
        n_k         = r_k;
        n_sum       = r_sum;
        n_best      = r_best;
        n_best_i    = r_best_i;
        n_best_pt   = r_best_pt;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_idx   = r_out_idx;
        n_out_sum   = r_out_sum;
        n_out_empty = r_out_empty;
        w_int_we    = 1'b0;
        w_bnd_we    = 1'b0;

        // Drop the result once the receiver has taken it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.action)
                        ACT_LOAD_INT: begin
                            if (r_int_cnt < CW_I'(MAX_INTERIOR)) begin
                                w_int_we  = 1'b1;
                                n_int_cnt = r_int_cnt + 1'b1;
                            end
                        end
                        ACT_LOAD_BND: begin
                            if (r_bnd_cnt < CW_B'(MAX_BOUNDARY)) begin
                                w_bnd_we  = 1'b1;
                                n_bnd_cnt = r_bnd_cnt + 1'b1;
                            end
                        end
                        ACT_COMPUTE: begin
                            n_i     = '0;
                            n_empty = (r_int_cnt == '0);
                            n_state = (r_int_cnt == '0) ? S_FINISH : S_INT_CAP;
                        end
                        ACT_CLEAR: begin
                            n_int_cnt = '0;
                            n_bnd_cnt = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INT_CAP: begin
                n_pt  = w_int_rd;
                n_sum = '0;
                n_j   = '0;
                n_state = (r_bnd_cnt == '0) ? S_CMP : S_DIFF;
            end

            S_DIFF: begin
                n_dx = (w_ax > w_bx) ? (w_ax - w_bx) : (w_bx - w_ax);
                n_dy = (w_ay > w_by) ? (w_ay - w_by) : (w_by - w_ay);
                n_state = S_SQX;
            end

            S_SQX: begin
                n_sqx   = w_prod;
                n_state = S_SQY;
            end

            S_SQY: begin
                n_rad   = RAD_W'(w_d2) << FRAC_SHIFT;
                n_root  = '0;
                n_rem   = '0;
                n_k     = KW'(ITER - 1);
                n_state = S_ROOT;
            end

            S_ROOT: begin
                n_rem  = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                n_root = {r_root[ITER-2:0], w_ge};
                n_rad  = r_rad << 2;
                n_k    = r_k - 1'b1;
                if (r_k == '0) begin
                    n_state = S_ACC;
                end
            end

            S_ACC: begin
                n_sum = w_acc[SUM_W] ? '1 : w_acc[SUM_W-1:0];
                n_j   = r_j + 1'b1;
                n_state = (n_j == r_bnd_cnt) ? S_CMP : S_DIFF;
            end

            S_CMP: begin
                if (r_i == '0 || r_sum < r_best) begin
                    n_best    = r_sum;
                    n_best_i  = r_i;
                    n_best_pt = r_pt;
                end
                n_i = r_i + 1'b1;
                n_state = (n_i == r_int_cnt) ? S_FINISH : S_INT_CAP;
            end

            S_FINISH: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_empty = r_empty;
                    if (r_empty) begin
                        n_out_x   = '0;
                        n_out_y   = '0;
                        n_out_idx = '0;
                        n_out_sum = '0;
                    end else begin
                        n_out_x   = PIX_W'(r_best_pt[PW-1 -: COORD_BITS]);
                        n_out_y   = PIX_W'(r_best_pt[COORD_BITS-1:0]);
                        n_out_idx = IDX_W'(r_best_i);
                        n_out_sum = r_best;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_int_cnt   <= '0;
            r_bnd_cnt   <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_int_cnt   <= n_int_cnt;
            r_bnd_cnt   <= n_bnd_cnt;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_empty     <= n_empty;
        r_pt        <= n_pt;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_sqx       <= n_sqx;
        r_rad       <= n_rad;
        r_root      <= n_root;
        r_rem       <= n_rem;
        r_k         <= n_k;
        r_sum       <= n_sum;
        r_best      <= n_best;
        r_best_i    <= n_best_i;
        r_best_pt   <= n_best_pt;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_idx   <= n_out_idx;
        r_out_sum   <= n_out_sum;
        r_out_empty <= n_out_empty;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.center_x       = r_out_x;
    assign o_out.center_y       = r_out_y;
    assign o_out.center_index   = r_out_idx;
    assign o_out.total_distance = r_out_sum;
    assign o_out.empty_res      = r_out_empty;

endmodule

// ----- hdl/msdc_chk.sv -----
`timescale 1ns / 1ps

module msdc_chk
    import msdc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input t_action          i_action,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_center_x,
    input logic [PIX_W-1:0] i_center_y,
    input logic [IDX_W-1:0] i_center_index,
    input logic [SUM_W-1:0] i_total_distance,
    input logic             i_empty_res
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // An empty result carries zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_res |->
            (i_center_x == '0) && (i_center_y == '0) &&
            (i_center_index == '0) && (i_total_distance == '0))
        else $error("empty result with non-zero fields");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // A compute occupies the block for at least the next cycle
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_action == ACT_COMPUTE) |=> !i_in_ready)
        else $error("input ready straight after compute");

endmodule

bind min_sum_distance_center msdc_chk u_msdc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_action         (i_in.action),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_center_x       (o_out.center_x),
    .i_center_y       (o_out.center_y),
    .i_center_index   (o_out.center_index),
    .i_total_distance (o_out.total_distance),
    .i_empty_res      (o_out.empty_res)
);
